// ===== hdl/djb2qp_pkg.sv =====
// Package for the DJB2 quadratic-probe hash table: sizes, codes and types.
// Depends on nothing; used by every module in hdl.
package djb2qp_pkg;

  localparam int TableDepth = 1024;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int SizeW      = SlotW + 1;
  localparam int KeyBytes   = 12;
  localparam int HashW      = 64;
  localparam logic [HashW-1:0] HashSeed = 64'd5381;
  localparam int HashShift  = 5;

  localparam int InW  = 1 + 32 + 64 + 31 + 16;
  localparam int InTW = ((InW + 7) / 8) * 8;
  localparam int OutW  = 2 + SlotW + 31 + 16;
  localparam int OutTW = ((OutW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_ADDR,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

endpackage

// ===== hdl/djb2_quadratic_probe_hash_table_top.sv =====
// Top level of the DJB2 quadratic-probe hash table: sequencer, slot memory
// and stream ports. Depends on djb2qp_pkg and djb2qp_mod.
//
//  Channel  Direction  Handshake             Payload
//  s_axis   in         s_axis_tvalid/tready  opcode, key, weight, order tag
//  m_axis   out        m_axis_tvalid/tready  status, slot, weight, order tag
//  cfg      in         cfg_we                slots_in_use (11 bits)
//
// One transfer at a time: the accept, the hashing of the 12 key bytes, the
// home-slot modulo (a start in S_MOD, then the shared bit-serial unit), then
// a read and a check of the home slot, which is also probe i = 0.
// Each further probe spends nearly all its time in the modulo of home + i*i,
// and a lookup miss or a full insert walks all eff_size probes.
// After reset the used bits are cleared one slot per cycle, all 1024 of them,
// and no input is taken until that pass ends. A result waits in the output
// register until taken; no input is taken meanwhile.
module djb2_quadratic_probe_hash_table_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [djb2qp_pkg::SizeW-1:0]       cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[0], key_high[32:1], key_low[96:33], entry_weight[127:97],
  // entry_order[143:128]
  input  logic [djb2qp_pkg::InTW-1:0]        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], slot[11:2], found_weight[42:12], found_order[58:43]
  output logic [djb2qp_pkg::OutTW-1:0]       m_axis_tdata
);
  import djb2qp_pkg::*;

  localparam int CntW = $clog2(KeyBytes + 1);

  // The size register and its clamped value.
  logic [SizeW-1:0] slots_in_use;
  logic [SizeW-1:0] eff_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SizeW'(TableDepth);
    end else if (cfg_we) begin
      slots_in_use <= cfg_data;
    end
  end

  always_comb begin
    eff_size = slots_in_use;
    if (slots_in_use == '0) eff_size = SizeW'(1);
    if (slots_in_use > SizeW'(TableDepth)) eff_size = SizeW'(TableDepth);
  end

  // Slot memory; the used bits are a memory too, emptied by the clearing pass.
  logic                  slot_used [TableDepth];
  logic [31:0]           mem_kh [TableDepth];
  logic [63:0]           mem_kl [TableDepth];
  logic [30:0]           mem_w  [TableDepth];
  logic [15:0]           mem_o  [TableDepth];
  logic [31:0]           rd_kh;
  logic [63:0]           rd_kl;
  logic [30:0]           rd_w;
  logic [15:0]           rd_o;
  logic                  rd_used;
  logic [SlotW-1:0]      clear_addr;

  // Item registers.
  state_t            state, state_next;
  opcode_t           op;
  logic [31:0]       key_high;
  logic [63:0]       key_low;
  logic [30:0]       entry_weight;
  logic [15:0]       entry_order;
  logic [HashW-1:0]  hash;
  logic [CntW-1:0]   byte_cnt;
  logic [SlotW-1:0]  home;
  logic [SizeW-1:0]  probe_i;
  logic [SlotW-1:0]  pos;
  logic              home_done;
  logic [OutW-1:0]   result;
  logic              out_valid;

  // Shared modulo unit.
  logic              mod_start;
  logic [HashW-1:0]  mod_dividend;
  logic              mod_done;
  logic [SlotW-1:0]  mod_rem;
  logic [2*SizeW:0]  probe_sum;
  logic [7:0]        cur_byte;

  assign probe_sum = {{(SizeW+2){1'b0}}, home} + probe_i * probe_i;

  djb2qp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (eff_size),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // Key bytes are consumed from the top of the 96-bit key shift register,
  // byte 0 (the top byte of key_high) first.
  logic [95:0] key_sh;
  assign cur_byte = key_sh[95:88];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutTW-OutW){1'b0}}, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mod_start    = 1'b0;
    mod_dividend = hash;
    unique case (state)
      S_CLEAR: if (clear_addr == SlotW'(TableDepth - 1)) state_next = S_IDLE;
      S_IDLE: if (s_axis_tvalid) state_next = S_HASH;
      S_HASH: if (byte_cnt == CntW'(1)) state_next = S_MOD;
      S_MOD: begin
        mod_start = 1'b1;
        if (home_done) mod_dividend = HashW'(probe_sum);
        state_next = S_ADDR;
      end
      S_ADDR: if (mod_done) state_next = S_READ;
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (op == OP_INSERT ? !rd_used
            : (rd_used && rd_kh == key_high && rd_kl == key_low)) begin
          state_next = S_OUT;
        end else if (probe_i + 1'b1 >= eff_size) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MOD;
        end
      end
      S_OUT: if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      home_done  <= 1'b0;
      clear_addr <= '0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clear_addr <= clear_addr + 1'b1;
        S_IDLE: home_done <= 1'b0;
        S_ADDR: if (mod_done) home_done <= 1'b1;
        S_CHECK: begin
          if (state_next == S_OUT) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op           <= opcode_t'(s_axis_tdata[0]);
          key_high     <= s_axis_tdata[32:1];
          key_low      <= s_axis_tdata[96:33];
          entry_weight <= s_axis_tdata[127:97];
          entry_order  <= s_axis_tdata[143:128];
          key_sh       <= {s_axis_tdata[32:1], s_axis_tdata[96:33]};
          hash         <= HashSeed;
          byte_cnt     <= CntW'(KeyBytes);
          probe_i      <= '0;
        end
      end
      S_HASH: begin
        hash     <= (hash << HashShift) + hash + HashW'(cur_byte);
        key_sh   <= {key_sh[87:0], 8'h00};
        byte_cnt <= byte_cnt - 1'b1;
      end
      S_ADDR: begin
        if (mod_done) begin
          if (!home_done) begin
            home <= mod_rem;
            pos  <= mod_rem;
          end else begin
            pos <= mod_rem;
          end
        end
      end
      S_CHECK: begin
        if (state_next == S_MOD) probe_i <= probe_i + 1'b1;
        if (op == OP_INSERT) begin
          if (!rd_used) begin
            result <= {16'd0, 31'd0, pos, ST_INSERTED};
          end else begin
            result <= {16'd0, 31'd0, {SlotW{1'b0}}, ST_FULL};
          end
        end else if (rd_used && rd_kh == key_high && rd_kl == key_low) begin
          result <= {rd_o, rd_w, pos, ST_FOUND};
        end else begin
          result <= {16'd0, 31'd0, {SlotW{1'b0}}, ST_NOT_FOUND};
        end
      end
      default: ;
    endcase
  end

  // The first modulo after hashing gives the home slot, which is also the
  // probe for i = 0, so that slot is read straight away. The used bits are
  // cleared one per cycle after reset and set by a successful insert.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_kh   <= mem_kh[pos];
      rd_kl   <= mem_kl[pos];
      rd_w    <= mem_w[pos];
      rd_o    <= mem_o[pos];
      rd_used <= slot_used[pos];
    end
    if (state == S_CLEAR) begin
      slot_used[clear_addr] <= 1'b0;
    end else if (state == S_CHECK && op == OP_INSERT && !rd_used) begin
      slot_used[pos] <= 1'b1;
    end
    if (state == S_CHECK && op == OP_INSERT && !rd_used) begin
      mem_kh[pos] <= key_high;
      mem_kl[pos] <= key_low;
      mem_w[pos]  <= entry_weight;
      mem_o[pos]  <= entry_order;
    end
  end

  // No new transfer is taken while a result is held.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // A result appears only after a probe check.
  a_out_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CHECK)
    else $error("result raised outside the probe check");

  // The probe index never reaches the table size.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> probe_i < eff_size)
    else $error("probe index beyond table size");

endmodule

// ===== hdl/djb2qp_mod.sv =====
// Restoring modulo unit: a 64-bit dividend reduced by an 11-bit divisor,
// one quotient bit per cycle. Depends on djb2qp_pkg.
module djb2qp_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [djb2qp_pkg::HashW-1:0]  dividend,
  input  logic [djb2qp_pkg::SizeW-1:0]  divisor,
  output logic                          done,
  output logic [djb2qp_pkg::SlotW-1:0]  remainder
);
  import djb2qp_pkg::*;

  localparam int CntW = $clog2(HashW + 1);

  logic [HashW-1:0] shreg;
  logic [SizeW:0]   rem;
  logic [SizeW-1:0] dvs;
  logic [CntW-1:0]  count;
  logic             busy;
  logic [SizeW:0]   trial;
  logic [SizeW:0]   diff;

  assign trial = {rem[SizeW-1:0], shreg[HashW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntW'(HashW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[HashW-2:0], 1'b0};
      rem   <= (trial >= {1'b0, dvs}) ? diff : trial;
    end
  end

  assign remainder = rem[SlotW-1:0];

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the DJB2 quadratic-probe hash table top level.
// Depends on djb2qp_pkg and the RTL in hdl; predicts every result internally.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import djb2qp_pkg::*;

  typedef struct {
    opcode_t     op;
    logic [31:0] kh;
    logic [63:0] kl;
    logic [30:0] w;
    logic [15:0] ord;
  } table_req_t;

  typedef struct {
    status_t     st;
    logic [9:0]  slot;
    logic [30:0] w;
    logic [15:0] ord;
  } table_rsp_t;

  localparam int IdleLimit = 300000;
  localparam int LongHold  = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [SizeW-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTW-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTW-1:0]     m_axis_tdata;

  djb2_quadratic_probe_hash_table_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the table and of its size register.
  logic [10:0]  shadow_size = 11'd1024;
  logic         shadow_used  [TableDepth];
  logic [31:0]  shadow_kh    [TableDepth];
  logic [63:0]  shadow_kl    [TableDepth];
  logic [30:0]  shadow_w     [TableDepth];
  logic [15:0]  shadow_ord   [TableDepth];

  table_req_t   pending_q[$];
  table_rsp_t   expected_q[$];
  logic [95:0]  stored_keys[$];

  table_req_t   cur_req;
  int           src_gap = 0;
  int           sink_gap = 0;
  int           idle_cycles = 0;
  int           errors = 0;
  int           in_flight = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;

  initial begin
    for (int n = 0; n < TableDepth; n++) shadow_used[n] = 1'b0;
  end

  // Works out the answer of the table to one operation and updates the shadow.
  function automatic table_rsp_t table_answer(table_req_t r);
    table_rsp_t  a;
    logic [63:0] h;
    logic [63:0] sz;
    logic [63:0] home;
    logic [63:0] pos;
    logic [7:0]  b;
    a.st = ST_INSERTED; a.slot = '0; a.w = '0; a.ord = '0;
    sz = (shadow_size == 0) ? 64'd1 : (shadow_size > TableDepth) ? 64'd1024 : 64'(shadow_size);
    h = HashSeed;
    for (int n = 0; n < KeyBytes; n++) begin
      b = (n < 4) ? 8'(r.kh >> (24 - 8 * n)) : 8'(r.kl >> (56 - 8 * (n - 4)));
      h = (h << HashShift) + h + 64'(b);
    end
    home = h % sz;
    for (longint i = 0; i < sz; i++) begin
      pos = (home + 64'(i) * 64'(i)) % sz;
      if (r.op == OP_INSERT) begin
        if (!shadow_used[pos]) begin
          shadow_used[pos] = 1'b1;
          shadow_kh[pos] = r.kh;
          shadow_kl[pos] = r.kl;
          shadow_w[pos] = r.w;
          shadow_ord[pos] = r.ord;
          a.slot = pos[9:0];
          return a;
        end
      end else if (shadow_used[pos] && shadow_kh[pos] == r.kh && shadow_kl[pos] == r.kl) begin
        a.st = ST_FOUND;
        a.slot = pos[9:0];
        a.w = shadow_w[pos];
        a.ord = shadow_ord[pos];
        return a;
      end
    end
    a.st = (r.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    return a;
  endfunction

  // Driver: presents queued operations, with short random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(table_answer(cur_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          in_flight++;
          s_axis_tdata <= InTW'({cur_req.ord, cur_req.w, cur_req.kl, cur_req.kh, cur_req.op});
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random back-pressure and checks each field.
  always @(posedge clk) begin
    table_rsp_t e;
    logic [1:0] got_st;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_st = m_axis_tdata[1:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          e = expected_q.pop_front();
          in_flight--;
          if (got_st !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.st, got_st);
            errors++;
          end
          if (m_axis_tdata[11:2] !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $realtime, e.slot, m_axis_tdata[11:2]);
            errors++;
          end
          if (m_axis_tdata[42:12] !== e.w) begin
            $display("%0t: weight expected %h actual %h", $realtime, e.w, m_axis_tdata[42:12]);
            errors++;
          end
          if (m_axis_tdata[58:43] !== e.ord) begin
            $display("%0t: order expected %h actual %h", $realtime, e.ord, m_axis_tdata[58:43]);
            errors++;
          end
        end
      end
      if (hold_req) begin
        sink_gap <= LongHold;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        sink_gap <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_op(opcode_t op, logic [31:0] kh, logic [63:0] kl,
                          logic [30:0] w, logic [15:0] ord);
    table_req_t r;
    r.op = op; r.kh = kh; r.kl = kl; r.w = w; r.ord = ord;
    pending_q.push_back(r);
    if (op == OP_INSERT) stored_keys.push_back({kh, kl});
  endtask

  // Waits until every queued operation has been answered, then a short
  // settling pause.
  task automatic drain();
    wait (pending_q.size() == 0 && in_flight == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(logic [10:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    shadow_size = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random operation: mostly inserts and lookups of stored keys, some
  // duplicates and some lookups of keys that were never stored.
  task automatic random_op();
    logic [95:0] k;
    int          pick;
    pick = $urandom_range(0, 99);
    if (stored_keys.size() > 0 && pick < 45)
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    else if (pick < 60)
      k = {64'h0, 32'($urandom_range(0, 255))};
    else
      k = {$urandom, $urandom, $urandom};
    if (pick < 40 || pick >= 88)
      queue_op(OP_LOOKUP, k[95:64], k[63:0], 31'($urandom), 16'($urandom));
    else
      queue_op(OP_INSERT, k[95:64], k[63:0], 31'($urandom), 16'($urandom));
  endtask

  initial begin
    int phases;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Full-size table: key and field extremes, hits, one full-walk miss.
    queue_op(OP_INSERT, 32'h0, 64'h0, 31'h0, 16'h0);
    queue_op(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    for (int n = 0; n < 6; n++)
      queue_op(OP_INSERT, $urandom, {$urandom, $urandom}, 31'($urandom), 16'($urandom));
    queue_op(OP_LOOKUP, 32'h0, 64'h0, 31'h7FFF_FFFF, 16'hFFFF);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 31'h0, 16'h0);
    queue_op(OP_LOOKUP, 32'h1234_5678, 64'h0, 31'h0, 16'h0);
    drain();

    // Oversized setting behaves as the full table; a duplicate insert must
    // leave the earlier copy as the one found.
    set_size(11'h7FF);
    queue_op(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 31'h1, 16'h1);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 31'h0, 16'h0);
    drain();

    // Size zero acts as one slot, so the table fills at once.
    set_size(11'd0);
    queue_op(OP_INSERT, 32'hA5A5_0000, 64'h1, 31'h55, 16'h66);
    queue_op(OP_INSERT, 32'hA5A5_0000, 64'h2, 31'h77, 16'h88);
    queue_op(OP_LOOKUP, 32'hA5A5_0000, 64'h2, 31'h0, 16'h0);
    drain();
    set_size(11'd1);
    queue_op(OP_INSERT, 32'h0, 64'h3, 31'h9, 16'h9);
    queue_op(OP_LOOKUP, 32'h0, 64'h0, 31'h0, 16'h0);
    drain();

    // Random phases over small sizes, including a long receiver hold-off
    // while the sender keeps offering, so the input stalls.
    phases = 15;
    for (int p = 0; p < phases; p++) begin
      set_size(11'($urandom_range(2, 40)));
      stored_keys.delete();
      calm = (p == phases - 1);
      for (int n = 0; n < 58; n++) random_op();
      if (p == 3) begin
        wait (pending_q.size() < 50);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      // The sender has nothing more until every answer of this phase is in.
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== djb2_quadratic_probe_hash_table_top.f =====
hdl/djb2qp_pkg.sv
hdl/djb2qp_mod.sv
hdl/djb2_quadratic_probe_hash_table_top.sv
tb/tb.sv
